>>> rtl/ctsl_pkg.sv
// Shared constants and types for the cooldown task schedule length block.
package ctsl_pkg;

  localparam int NumKinds   = 26;
  localparam int MaxTasks   = 4096;
  localparam int KindW      = 5;
  localparam int CntW       = 13;
  localparam int CycW       = 21;
  localparam int GapW       = 8;
  localparam int KidxW      = $clog2(NumKinds);

  localparam logic [CycW-1:0] CyclesMax = {CycW{1'b1}};

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

endpackage

>>> rtl/ctsl_peak_scan.sv
// Peak count and peak multiplicity scan over the kind counters, one kind a cycle.
module ctsl_peak_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          step_i,
  input  logic [ctsl_pkg::CntW-1:0]     count_i,
  output logic [ctsl_pkg::CntW-1:0]     peak_o,
  output logic [ctsl_pkg::KindW+1:0]    at_peak_o
);

  logic [ctsl_pkg::CntW-1:0]  peak_q, peak_d;
  logic [ctsl_pkg::KindW+1:0] at_q, at_d;

  always_comb begin
    peak_d = peak_q;
    at_d   = at_q;
    if (start_i) begin
      peak_d = '0;
      at_d   = '0;
    end else if (step_i) begin
      if (count_i > peak_q) begin
        peak_d = count_i;
        at_d   = (ctsl_pkg::KindW+2)'(1);
      end else if (count_i == peak_q && peak_q != '0) begin
        at_d = at_q + (ctsl_pkg::KindW+2)'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      at_q   <= '0;
    end else begin
      peak_q <= peak_d;
      at_q   <= at_d;
    end
  end

  assign peak_o    = peak_q;
  assign at_peak_o = at_q;

endmodule

>>> rtl/cooldown_task_schedule_length.sv
// Top level of the cooldown task schedule length block.
//
//  channel   | dir | fields (lsb first)                     | accept
//  s_axis_*  | in  | tdata[4:0] task_kind, tlast last_task  | tvalid & tready
//  m_axis_*  | out | tdata[20:0] total_cycles, tuser overflow | tvalid & tready
//  cfg_*     | in  | cfg_data_i[7:0] cooldown_gap           | cfg_valid_i & cfg_ready_o
//
// Each beat, the final one too, is counted in the cycle it is accepted. After
// a final beat the CLEAR state resets the scan, the SCAN state steps through
// the kind counters (one kind a cycle) and the MUL state forms the length,
// which the OUT state then holds valid. The input is ready again from the edge
// that takes the result beat. Counters are cleared during the scan (read then
// zeroed per kind).
// Reset clears the counters, totals, flags and the gap register. The input
// and the config channel are not ready while a schedule is worked out or a
// result is pending.
module cooldown_task_schedule_length (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] task_kind, zero fill above
  input  logic        s_axis_tlast,   // last_task
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] total_cycles, zero fill above
  output logic        m_axis_tuser,   // overflow
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i      // cooldown_gap
);

  localparam int CntW  = ctsl_pkg::CntW;
  localparam int KidxW = ctsl_pkg::KidxW;

  ctsl_pkg::state_e state_q, state_d;

  logic [CntW-1:0]           counts_q [ctsl_pkg::NumKinds];
  logic [CntW:0]             total_q;
  logic                      drop_q;
  logic [ctsl_pkg::GapW-1:0] gap_q;
  logic [KidxW-1:0]          idx_q;
  logic [ctsl_pkg::CycW-1:0] res_q;
  logic                      ovf_q;

  logic                      in_acc;
  logic                      cfg_acc;
  logic [4:0]                kind;
  logic                      kind_ok;
  logic                      scan_step;
  logic [CntW-1:0]           peak;
  logic [CntW-1:0]           peak_m1;
  logic [ctsl_pkg::KindW+1:0] at_peak;
  logic [CntW-1:0]           cur_count;
  logic [CntW+ctsl_pkg::GapW:0] frame;
  logic [CntW+ctsl_pkg::GapW+1:0] frame_k;

  assign s_axis_tready = state_q == ctsl_pkg::ST_LOAD;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tdata[4:0];
  assign kind_ok       = kind < 5'(ctsl_pkg::NumKinds);
  // hold the gap steady while a schedule is worked out
  assign cfg_ready_o   = state_q == ctsl_pkg::ST_LOAD;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign scan_step     = state_q == ctsl_pkg::ST_SCAN;
  assign cur_count     = counts_q[idx_q];

  ctsl_peak_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ctsl_pkg::ST_CLEAR),
    .step_i    (scan_step),
    .count_i   (cur_count),
    .peak_o    (peak),
    .at_peak_o (at_peak)
  );

  // (peak - 1) * (gap + 1) + at_peak, compared to the total and saturated
  assign peak_m1 = peak - CntW'(1);
  assign frame   = {{(ctsl_pkg::GapW+1){1'b0}}, peak_m1} *
                   {{CntW{1'b0}}, ({1'b0, gap_q} + 9'd1)};
  assign frame_k = {1'b0, frame} + (CntW+ctsl_pkg::GapW+2)'(at_peak);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ctsl_pkg::ST_LOAD:  if (in_acc && s_axis_tlast) state_d = ctsl_pkg::ST_CLEAR;
      ctsl_pkg::ST_CLEAR: state_d = ctsl_pkg::ST_SCAN;
      ctsl_pkg::ST_SCAN:
        if (idx_q == KidxW'(ctsl_pkg::NumKinds - 1)) state_d = ctsl_pkg::ST_MUL;
      ctsl_pkg::ST_MUL:   state_d = ctsl_pkg::ST_OUT;
      ctsl_pkg::ST_OUT:   if (m_axis_tready) state_d = ctsl_pkg::ST_LOAD;
      default:            state_d = ctsl_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctsl_pkg::ST_LOAD;
      for (int i = 0; i < ctsl_pkg::NumKinds; i++) counts_q[i] <= '0;
      total_q <= '0;
      drop_q  <= 1'b0;
      gap_q   <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) gap_q <= cfg_data_i;
      // count the beat; a final beat counts too before the scan
      if (in_acc && kind_ok) begin
        if (total_q < (CntW+1)'(ctsl_pkg::MaxTasks)) begin
          counts_q[kind[KidxW-1:0]] <= counts_q[kind[KidxW-1:0]] + CntW'(1);
          total_q <= total_q + (CntW+1)'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (state_q == ctsl_pkg::ST_CLEAR) idx_q <= '0;
      if (scan_step) begin
        counts_q[idx_q] <= '0;   // drop each count once read
        idx_q <= idx_q + KidxW'(1);
      end
      if (state_q == ctsl_pkg::ST_MUL) begin
        if (total_q == '0) res_q <= '0;
        else if (frame_k < (CntW+ctsl_pkg::GapW+2)'(total_q)) res_q <= 21'(total_q);
        else if (frame_k > (CntW+ctsl_pkg::GapW+2)'(ctsl_pkg::CyclesMax))
          res_q <= ctsl_pkg::CyclesMax;
        else res_q <= 21'(frame_k);
        ovf_q   <= drop_q;
        total_q <= '0;
        drop_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = state_q == ctsl_pkg::ST_OUT;
  assign m_axis_tdata  = {3'b000, res_q};
  assign m_axis_tuser  = ovf_q;

endmodule
